### src/bdd_pkg.sv
// Shared types, constants and stencil tables for the derivative bank.
`timescale 1ns / 1ps
package bdd_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int RESULT_WIDTH_DEF = 48;

   localparam int NUM_TAPS   = 9;
   localparam int NUM_ORDERS = 8;
   localparam int TAP_IDX_W  = 4;
   localparam int ORD_IDX_W  = 3;
   localparam int COEF_W     = 20;

   localparam int MUL_W      = 33;
   localparam int MAG_W      = 64;
   localparam int HALF_W     = 32;
   localparam int STEP_W     = 16;
   localparam int LO_W       = HALF_W + STEP_W;
   localparam int SCALE_W    = LO_W + HALF_W;

   localparam int DIGIT_W     = 8;
   localparam int NUM_DIGITS  = MAG_W / DIGIT_W;
   localparam int DIGIT_IDX_W = 3;
   localparam int REM_W       = 9;
   localparam int DIV_VAL_W   = REM_W + DIGIT_W;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 32;
   localparam int SHIFT_W     = 3;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_BIT = 2;
   localparam logic REG_INV_STEP = 1'b0;
   localparam logic [STEP_W-1:0] INV_STEP_RESET = 16'd1;

   localparam logic [MAG_W-1:0] MAG_NEG_LIM = 64'h8000_0000_0000_0000;
   localparam logic [MAG_W-1:0] MAG_POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAC,
      S_ABS,
      S_SCALE_LO,
      S_SCALE_HI,
      S_SCALE_SUM,
      S_DIV_PREP,
      S_DIV_MUL,
      S_DIV_STEP,
      S_FINISH,
      S_OUT
   } state_type;

   typedef logic signed [COEF_W-1:0] coef_type;

   // tap 0 newest, tap 8 oldest
   localparam coef_type COEF_TABLE [NUM_ORDERS][NUM_TAPS] = '{
      '{20'sd2283, -20'sd6720, 20'sd11760, -20'sd15680, 20'sd14700,
        -20'sd9408, 20'sd3920, -20'sd960, 20'sd105},
      '{20'sd29531, -20'sd138528, 20'sd312984, -20'sd448672, 20'sd435330,
        -20'sd284256, 20'sd120008, -20'sd29664, 20'sd3267},
      '{20'sd2403, -20'sd13960, 20'sd36706, -20'sd57384, 20'sd58280,
        -20'sd39128, 20'sd16830, -20'sd4216, 20'sd469},
      '{20'sd3207, -20'sd21056, 20'sd61156, -20'sd102912, 20'sd109930,
        -20'sd76352, 20'sd33636, -20'sd8576, 20'sd967},
      '{20'sd81, -20'sd575, 20'sd1790, -20'sd3195, 20'sd3580,
        -20'sd2581, 20'sd1170, -20'sd305, 20'sd35},
      '{20'sd39, -20'sd292, 20'sd956, -20'sd1788, 20'sd2090,
        -20'sd1564, 20'sd732, -20'sd196, 20'sd23},
      '{20'sd9, -20'sd70, 20'sd238, -20'sd462, 20'sd560,
        -20'sd434, 20'sd210, -20'sd58, 20'sd7},
      '{20'sd1, -20'sd8, 20'sd28, -20'sd56, 20'sd70,
        -20'sd56, 20'sd28, -20'sd8, 20'sd1}
   };

   // denominator = odd part << shift: 840, 5040, 240, 240, 6, 4, 2, 1
   localparam logic [SHIFT_W-1:0] DEN_SHIFT [NUM_ORDERS] = '{
      3'd3, 3'd4, 3'd4, 3'd4, 3'd1, 3'd2, 3'd1, 3'd0
   };

   localparam logic [REM_W-1:0] DEN_ODD [NUM_ORDERS] = '{
      9'd105, 9'd315, 9'd15, 9'd15, 9'd3, 9'd1, 9'd1, 9'd1
   };

   // ceil(2^32 / odd part); zero where the odd part is one
   localparam logic [RECIP_W-1:0] DEN_RECIP [NUM_ORDERS] = '{
      32'd40904451, 32'd13634817, 32'd286331154, 32'd286331154,
      32'd1431655766, 32'd0, 32'd0, 32'd0
   };

endpackage

### src/bdd_req_if.sv
// Request channel: one signed sample per request.
`timescale 1ns / 1ps
interface bdd_req_if #(
   parameter int SAMPLE_WIDTH = bdd_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### src/bdd_rsp_if.sv
// Response channel: sample and derivative estimates of orders one to eight.
`timescale 1ns / 1ps
interface bdd_rsp_if #(
   parameter int SAMPLE_WIDTH = bdd_pkg::SAMPLE_WIDTH_DEF,
   parameter int RESULT_WIDTH = bdd_pkg::RESULT_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] value;
   logic signed [RESULT_WIDTH-1:0] deriv_first;
   logic signed [RESULT_WIDTH-1:0] deriv_second;
   logic signed [RESULT_WIDTH-1:0] deriv_third;
   logic signed [RESULT_WIDTH-1:0] deriv_fourth;
   logic signed [RESULT_WIDTH-1:0] deriv_fifth;
   logic signed [RESULT_WIDTH-1:0] deriv_sixth;
   logic signed [RESULT_WIDTH-1:0] deriv_seventh;
   logic signed [RESULT_WIDTH-1:0] deriv_eighth;
   logic                           overflow;

   modport source (
      output valid, output value, output deriv_first, output deriv_second,
      output deriv_third, output deriv_fourth, output deriv_fifth,
      output deriv_sixth, output deriv_seventh, output deriv_eighth,
      output overflow, input ready
   );
   modport sink (
      input valid, input value, input deriv_first, input deriv_second,
      input deriv_third, input deriv_fourth, input deriv_fifth,
      input deriv_sixth, input deriv_seventh, input deriv_eighth,
      input overflow, output ready
   );
endinterface

### src/backward_difference_derivative_bank_core.sv
// Nine-tap backward-difference derivative bank on one shared multiplier.
//
// Usage:
//   req_ch carries one signed sample per request (valid/ready). rsp_ch
//   returns that sample with derivative estimates of orders one to eight
//   and a saturation flag. The csr_ APB port holds inv_step at address 0.
// Sequencing:
//   One request is worked through and its response loaded before the next
//   request is taken. Per order: multiply-accumulate over the taps, inv_step
//   scaling (order k scales k times), and radix-256 division by the odd
//   part of the denominator for orders one to five. All of it runs through
//   a single 33x33 multiplier. req_ch.ready is high only between requests.
// Reset:
//   Clears the sample history to zero, inv_step to one, drops rsp valid.
// Stall:
//   The response sits in an output register; the next request is accepted
//   and processed meanwhile, and its result waits until that register frees.
`timescale 1ns / 1ps
module backward_difference_derivative_bank_core #(
   parameter int SAMPLE_WIDTH = bdd_pkg::SAMPLE_WIDTH_DEF,
   parameter int RESULT_WIDTH = bdd_pkg::RESULT_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bdd_req_if.sink                           req_ch,
   bdd_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bdd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bdd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bdd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import bdd_pkg::*;

   localparam int SUM_W = SAMPLE_WIDTH + 22;
   localparam logic [MAG_W-1:0] RES_LIM = MAG_W'(1) << (RESULT_WIDTH - 1);

   state_type state_ff, state_in;

   logic [STEP_W-1:0]                inv_step_ff, inv_step_in;
   logic signed [SAMPLE_WIDTH-1:0]   taps_ff [NUM_TAPS];
   logic signed [SAMPLE_WIDTH-1:0]   taps_in [NUM_TAPS];
   logic [ORD_IDX_W-1:0]             ord_ff, ord_in;
   logic [TAP_IDX_W-1:0]             tap_ff, tap_in;
   logic [ORD_IDX_W-1:0]             rep_ff, rep_in;
   logic [DIGIT_IDX_W-1:0]           dig_ff, dig_in;
   logic signed [SUM_W-1:0]          acc_ff, acc_in;
   logic signed [2*MUL_W-1:0]        mul_ff, mul_in;
   logic [MAG_W-1:0]                 mag_ff, mag_in;
   logic                             neg_ff, neg_in;
   logic [LO_W-1:0]                  lo_ff, lo_in;
   logic [MAG_W-1:0]                 quo_ff, quo_in;
   logic [REM_W-1:0]                 rem_ff, rem_in;
   logic                             ovf_ff, ovf_in;
   logic signed [RESULT_WIDTH-1:0]   res_ff [NUM_ORDERS];
   logic signed [RESULT_WIDTH-1:0]   res_in [NUM_ORDERS];

   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]   out_value_ff, out_value_in;
   logic signed [RESULT_WIDTH-1:0]   out_deriv_ff [NUM_ORDERS];
   logic signed [RESULT_WIDTH-1:0]   out_deriv_in [NUM_ORDERS];
   logic                             out_ovf_ff, out_ovf_in;

   logic signed [MUL_W-1:0]          mul_a, mul_b;
   logic                             req_fire;
   logic                             out_load;
   logic [TAP_IDX_W-1:0]             tap_idx;
   logic [MAG_W-1:0]                 acc_ext;
   logic [SCALE_W-1:0]               scale_full;
   logic                             scale_sat;
   logic [DIV_VAL_W-1:0]             div_value;
   logic [DIGIT_W-1:0]               q_digit;
   logic [DIV_VAL_W-1:0]             div_rem_full;
   logic [MAG_W-1:0]                 fin_q;
   logic                             fin_sat;
   logic signed [RESULT_WIDTH-1:0]   fin_res;
   logic                             csr_write;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_IDX_BIT] == REG_INV_STEP);
   assign csr_prdata = (csr_paddr[CSR_IDX_BIT] == REG_INV_STEP) ?
                       CSR_DATA_W'(inv_step_ff) : '0;
   assign inv_step_in = csr_write ? csr_pwdata[STEP_W-1:0] : inv_step_ff;

   // shared arithmetic
   assign tap_idx  = (tap_ff < TAP_IDX_W'(NUM_TAPS)) ? tap_ff : '0;
   assign mul_in   = mul_a * mul_b;
   assign acc_ext  = MAG_W'(acc_ff);
   assign scale_full = {mul_ff[LO_W-1:0], HALF_W'(0)} + SCALE_W'(lo_ff);
   assign scale_sat  = scale_full > SCALE_W'(neg_ff ? MAG_NEG_LIM : MAG_POS_LIM);
   assign div_value  = {rem_ff, mag_ff[MAG_W-1 -: DIGIT_W]};
   assign q_digit    = mul_ff[RECIP_SHIFT +: DIGIT_W];
   assign div_rem_full = div_value
                         - DIV_VAL_W'(q_digit) * DIV_VAL_W'(DEN_ODD[ord_ff]);

   always_comb begin
      if (neg_ff) begin
         fin_sat = quo_ff > RES_LIM;
         fin_q   = fin_sat ? RES_LIM : quo_ff;
         fin_res = RESULT_WIDTH'(MAG_W'(0) - fin_q);
      end else begin
         fin_sat = quo_ff >= RES_LIM;
         fin_q   = fin_sat ? (RES_LIM - MAG_W'(1)) : quo_ff;
         fin_res = RESULT_WIDTH'(fin_q);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_ch.valid) state_in = S_MAC;
         S_MAC:       if (tap_ff == TAP_IDX_W'(NUM_TAPS)) state_in = S_ABS;
         S_ABS:       state_in = S_SCALE_LO;
         S_SCALE_LO:  state_in = S_SCALE_HI;
         S_SCALE_HI:  state_in = S_SCALE_SUM;
         S_SCALE_SUM: state_in = (rep_ff == ord_ff) ? S_DIV_PREP : S_SCALE_LO;
         S_DIV_PREP:  state_in = (DEN_ODD[ord_ff] == REM_W'(1)) ? S_FINISH : S_DIV_MUL;
         S_DIV_MUL:   state_in = S_DIV_STEP;
         S_DIV_STEP:  state_in = (dig_ff == DIGIT_IDX_W'(NUM_DIGITS - 1)) ?
                                 S_FINISH : S_DIV_MUL;
         S_FINISH:    state_in = (ord_ff == ORD_IDX_W'(NUM_ORDERS - 1)) ? S_OUT : S_MAC;
         S_OUT:       if (out_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer: handshake and multiplier operands
   always_comb begin
      req_ch.ready = 1'b0;
      out_load     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         S_IDLE: req_ch.ready = 1'b1;
         S_MAC: begin
            mul_a = MUL_W'(taps_ff[tap_idx]);
            mul_b = MUL_W'(COEF_TABLE[ord_ff][tap_idx]);
         end
         S_SCALE_LO: begin
            mul_a = MUL_W'(mag_ff[HALF_W-1:0]);
            mul_b = MUL_W'(inv_step_ff);
         end
         S_SCALE_HI: begin
            mul_a = MUL_W'(mag_ff[MAG_W-1:HALF_W]);
            mul_b = MUL_W'(inv_step_ff);
         end
         S_DIV_MUL: begin
            mul_a = MUL_W'(div_value);
            mul_b = MUL_W'(DEN_RECIP[ord_ff]);
         end
         S_OUT: out_load = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign req_fire = req_ch.valid && req_ch.ready;

   // datapath next values
   always_comb begin
      taps_in = taps_ff;
      ord_in  = ord_ff;
      tap_in  = tap_ff;
      rep_in  = rep_ff;
      dig_in  = dig_ff;
      acc_in  = acc_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      ovf_in  = ovf_ff;
      res_in  = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               taps_in[0] = req_ch.sample;
               for (int j = 1; j < NUM_TAPS; j++) begin
                  taps_in[j] = taps_ff[j-1];
               end
               ord_in = '0;
               tap_in = '0;
               rep_in = '0;
               acc_in = '0;
               ovf_in = 1'b0;
            end
         end
         S_MAC: begin
            tap_in = tap_ff + TAP_IDX_W'(1);
            if (tap_ff != '0) begin
               acc_in = acc_ff + SUM_W'(mul_ff);
            end
         end
         S_ABS: begin
            neg_in = acc_ff[SUM_W-1];
            mag_in = acc_ff[SUM_W-1] ? (MAG_W'(0) - acc_ext) : acc_ext;
            rep_in = '0;
         end
         S_SCALE_HI: lo_in = mul_ff[LO_W-1:0];
         S_SCALE_SUM: begin
            if (scale_sat) begin
               mag_in = neg_ff ? MAG_NEG_LIM : MAG_POS_LIM;
               ovf_in = 1'b1;
            end else begin
               mag_in = scale_full[MAG_W-1:0];
            end
            if (rep_ff != ord_ff) begin
               rep_in = rep_ff + ORD_IDX_W'(1);
            end
         end
         S_DIV_PREP: begin
            mag_in = mag_ff >> DEN_SHIFT[ord_ff];
            quo_in = mag_ff >> DEN_SHIFT[ord_ff];
            rem_in = '0;
            dig_in = '0;
         end
         S_DIV_STEP: begin
            quo_in = {quo_ff[MAG_W-DIGIT_W-1:0], q_digit};
            mag_in = mag_ff << DIGIT_W;
            rem_in = div_rem_full[REM_W-1:0];
            dig_in = dig_ff + DIGIT_IDX_W'(1);
         end
         S_FINISH: begin
            res_in[ord_ff] = fin_res;
            if (fin_sat) begin
               ovf_in = 1'b1;
            end
            if (ord_ff != ORD_IDX_W'(NUM_ORDERS - 1)) begin
               ord_in = ord_ff + ORD_IDX_W'(1);
            end
            tap_in = '0;
            acc_in = '0;
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_value_in = out_value_ff;
      out_deriv_in = out_deriv_ff;
      out_ovf_in   = out_ovf_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         out_value_in = taps_ff[0];
         out_deriv_in = res_ff;
         out_ovf_in   = ovf_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.value         = out_value_ff;
   assign rsp_ch.deriv_first   = out_deriv_ff[0];
   assign rsp_ch.deriv_second  = out_deriv_ff[1];
   assign rsp_ch.deriv_third   = out_deriv_ff[2];
   assign rsp_ch.deriv_fourth  = out_deriv_ff[3];
   assign rsp_ch.deriv_fifth   = out_deriv_ff[4];
   assign rsp_ch.deriv_sixth   = out_deriv_ff[5];
   assign rsp_ch.deriv_seventh = out_deriv_ff[6];
   assign rsp_ch.deriv_eighth  = out_deriv_ff[7];
   assign rsp_ch.overflow      = out_ovf_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         inv_step_ff  <= INV_STEP_RESET;
         ord_ff       <= '0;
         tap_ff       <= '0;
         rep_ff       <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_TAPS; j++) begin
            taps_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         inv_step_ff  <= inv_step_in;
         ord_ff       <= ord_in;
         tap_ff       <= tap_in;
         rep_ff       <= rep_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
         taps_ff      <= taps_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mul_ff       <= mul_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      lo_ff        <= lo_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      ovf_ff       <= ovf_in;
      res_ff       <= res_in;
      out_value_ff <= out_value_in;
      out_deriv_ff <= out_deriv_in;
      out_ovf_ff   <= out_ovf_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_MAC) && (ord_ff == '0) && (tap_ff == '0))
      else $error("request did not start order one");

   a_rep_bound: assert property (@(posedge clock) disable iff (reset)
      rep_ff <= ord_ff)
      else $error("scaling count ran past order");

   a_digit_exact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP) |-> (div_rem_full < DIV_VAL_W'(DEN_ODD[ord_ff])))
      else $error("reciprocal quotient digit off by one");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("second request taken while busy");

endmodule

### tb/tb_backward_difference_derivative_bank_core.sv
// Self-checking testbench for the nine-tap backward-difference derivative bank.
`timescale 1ns / 1ps
module tb_backward_difference_derivative_bank_core;

   localparam int SW = bdd_pkg::SAMPLE_WIDTH_DEF;
   localparam int RW = bdd_pkg::RESULT_WIDTH_DEF;
   localparam int ORDERS = 8;
   localparam int TAPS = 9;

   localparam int INV_STEP_INDEX = 0;
   localparam int SPARE_INDEX = 1;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 2000;
   localparam int DRAIN_CYCLES = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_REQUESTS = 75;

   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] RES_NEG = 64'd1 << (RW - 1);
   localparam logic [63:0] RES_POS = (64'd1 << (RW - 1)) - 64'd1;

   // tap 0 is the newest sample
   localparam longint STENCIL [ORDERS][TAPS] = '{
      '{2283, -6720, 11760, -15680, 14700, -9408, 3920, -960, 105},
      '{29531, -138528, 312984, -448672, 435330, -284256, 120008, -29664, 3267},
      '{2403, -13960, 36706, -57384, 58280, -39128, 16830, -4216, 469},
      '{3207, -21056, 61156, -102912, 109930, -76352, 33636, -8576, 967},
      '{81, -575, 1790, -3195, 3580, -2581, 1170, -305, 35},
      '{39, -292, 956, -1788, 2090, -1564, 732, -196, 23},
      '{9, -70, 238, -462, 560, -434, 210, -58, 7},
      '{1, -8, 28, -56, 70, -56, 28, -8, 1}
   };
   localparam logic [63:0] DENOM [ORDERS] = '{840, 5040, 240, 240, 6, 4, 2, 1};

   typedef struct packed {
      logic [SW-1:0]              value;
      logic [ORDERS-1:0][RW-1:0]  deriv;
      logic                       overflow;
   } bank_estimate_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [bdd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [bdd_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [bdd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   bdd_req_if #(.SAMPLE_WIDTH(SW)) req_ch ();
   bdd_rsp_if #(.SAMPLE_WIDTH(SW), .RESULT_WIDTH(RW)) rsp_ch ();

   backward_difference_derivative_bank_core #(
      .SAMPLE_WIDTH(SW),
      .RESULT_WIDTH(RW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   logic signed [SW-1:0] pending_samples [$];
   bank_estimate_type expected_estimates [$];
   logic signed [SW-1:0] sample_history [TAPS-1];
   logic [15:0] step_reg;
   int errors;

   int burst_left;
   int gap_left;
   int stall_mode;
   int pattern_left;
   int hold_left;
   bit hold_done;
   bit pressure_armed;
   int idle_cycles;
   bank_estimate_type seen;
   bank_estimate_type want;
   string order_name [ORDERS] = '{"deriv_first", "deriv_second", "deriv_third",
      "deriv_fourth", "deriv_fifth", "deriv_sixth", "deriv_seventh", "deriv_eighth"};

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic bank_estimate_type derive_estimates(input logic signed [SW-1:0] sample);
      bank_estimate_type est;
      longint signed taps [TAPS];
      longint signed total;
      logic [63:0] mag;
      logic [63:0] lim;
      logic [63:0] quot;
      logic negative;
      int j;
      int k;
      int m;
      est = '0;
      est.value = sample;
      taps[0] = sample;
      for (j = 1; j < TAPS; j++) taps[j] = sample_history[j-1];
      for (k = 0; k < ORDERS; k++) begin
         total = 0;
         for (j = 0; j < TAPS; j++) total += STENCIL[k][j] * taps[j];
         negative = total < 0;
         mag = negative ? 64'(-total) : 64'(total);
         lim = negative ? NEG_LIMIT : POS_LIMIT;
         for (m = 0; m <= k; m++) begin
            if (step_reg != 0 && mag > lim / {48'd0, step_reg}) begin
               mag = lim;
               est.overflow = 1'b1;
            end else begin
               mag = mag * {48'd0, step_reg};
            end
         end
         quot = mag / DENOM[k];
         if (negative) begin
            if (quot > RES_NEG) begin
               quot = RES_NEG;
               est.overflow = 1'b1;
            end
            est.deriv[k] = RW'(-quot);
         end else begin
            if (quot > RES_POS) begin
               quot = RES_POS;
               est.overflow = 1'b1;
            end
            est.deriv[k] = RW'(quot);
         end
      end
      for (j = TAPS - 2; j > 0; j--) sample_history[j] = sample_history[j-1];
      sample_history[0] = sample;
      return est;
   endfunction

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.sample <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_estimates.push_back(derive_estimates(req_ch.sample));
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_ch.valid <= 1'b1;
               req_ch.sample <= pending_samples.pop_front();
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_mode <= 0;
         pattern_left <= 0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.value = rsp_ch.value;
            seen.deriv = {rsp_ch.deriv_eighth, rsp_ch.deriv_seventh, rsp_ch.deriv_sixth,
                          rsp_ch.deriv_fifth, rsp_ch.deriv_fourth, rsp_ch.deriv_third,
                          rsp_ch.deriv_second, rsp_ch.deriv_first};
            seen.overflow = rsp_ch.overflow;
            if (expected_estimates.size() == 0) begin
               $display("%0t: response with no request outstanding, value %h", $time,
                        seen.value);
               errors++;
            end else begin
               want = expected_estimates.pop_front();
               if (seen.value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h", $time,
                           want.value, seen.value);
                  errors++;
               end
               for (int k = 0; k < ORDERS; k++) begin
                  if (seen.deriv[k] !== want.deriv[k]) begin
                     $display("%0t: %s mismatch, expected %h, actual %h", $time,
                              order_name[k], want.deriv[k], seen.deriv[k]);
                     errors++;
                  end
               end
               if (seen.overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch, expected %b, actual %b", $time,
                           want.overflow, seen.overflow);
                  errors++;
               end
            end
         end
         if (pattern_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            pattern_left <= $urandom_range(20, 600);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         if (pressure_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= $urandom_range(0, 1);
               2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 15) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic csr_write(input int index, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= bdd_pkg::CSR_ADDR_W'(index * 4);
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == INV_STEP_INDEX) step_reg = data[15:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic csr_check(input int index);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= bdd_pkg::CSR_ADDR_W'(index * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'd0, step_reg}) begin
         $display("%0t: inv_step read mismatch, expected %h, actual %h", $time,
                  {16'd0, step_reg}, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || req_ch.valid || expected_estimates.size() != 0)
         @(negedge clock);
   endtask

   task automatic queue_shaped(input int count);
      int made;
      int shape;
      int seg_len;
      int base;
      int slope;
      int curve;
      int level;
      made = 0;
      while (made < count) begin
         shape = $urandom_range(0, 10);
         seg_len = $urandom_range(4, 24);
         base = $urandom_range(0, 65535);
         base -= 32768;
         slope = $urandom_range(0, 2000);
         slope -= 1000;
         curve = $urandom_range(0, 40);
         curve -= 20;
         for (int i = 0; i < seg_len && made < count; i++) begin
            case (shape)
               0, 1, 2: level = base + slope * i;
               3, 4, 5: level = base + slope * i + curve * i * i;
               6: level = (i % 2 == 1) ? 32767 : -32768;
               7: level = $urandom_range(0, 16) - 8;
               default: level = $urandom_range(0, 65535) - 32768;
            endcase
            if (level > 32767) level = 32767;
            if (level < -32768) level = -32768;
            pending_samples.push_back(SW'(level));
            made++;
         end
      end
   endtask

   initial begin
      logic [15:0] step;
      errors = 0;
      idle_cycles = 0;
      pressure_armed = 1'b0;
      step_reg = 16'd1;
      for (int j = 0; j < TAPS - 1; j++) sample_history[j] = '0;
      reset <= 1'b1;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // warm-up from the zeroed history at the reset step, extremes of the sample
      pending_samples = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh0000,
                          16'sh0001, -16'sh0001, 16'sh0000, -16'sh8000, -16'sh8000,
                          16'sh7FFF, 16'sh5A5A};
      drain();
      csr_check(INV_STEP_INDEX);

      // write to an unused index is ignored, then the largest step saturates
      csr_write(SPARE_INDEX, 32'h0000_0005);
      csr_check(INV_STEP_INDEX);
      csr_write(INV_STEP_INDEX, 32'hABCD_FFFF);
      csr_check(INV_STEP_INDEX);
      for (int i = 0; i < 9; i++)
         pending_samples.push_back((i % 2 == 0) ? 16'sh7FFF : -16'sh8000);
      drain();

      // zero step clears every order and the overflow flag
      csr_write(INV_STEP_INDEX, 32'hFFFF_0000);
      csr_check(INV_STEP_INDEX);
      pending_samples = '{-16'sh8000, 16'sh7FFF, 16'sh1234};
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 8)
            0: step = 16'hFFFF;
            1: step = 16'd0;
            2: step = 16'd1;
            3: step = 16'd2;
            4: step = 16'($urandom_range(3, 12));
            5: step = 16'($urandom_range(100, 3000));
            6: step = 16'($urandom);
            default: step = 16'($urandom_range(13, 99));
         endcase
         if ($urandom_range(0, 3) == 0) csr_write(SPARE_INDEX, $urandom);
         csr_write(INV_STEP_INDEX, {16'($urandom), step});
         csr_check(INV_STEP_INDEX);
         if (p == 3) pressure_armed = 1'b1;
         queue_shaped(PHASE_REQUESTS);
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_estimates.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_estimates.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
